FILE: rtl/srlof_pkg.sv
// ----------------------------------------------------------------------------
// srlof_pkg
// Shared types, register indexes, reset values and saturation helper for the
// stereo RC output filter.
// ----------------------------------------------------------------------------
package srlof_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FILTER_MODE   = 3'd0,
    REG_MASTER_VOLUME = 3'd1,
    REG_LOWPASS_ALPHA = 3'd2,
    REG_HP_ALPHA_PRI  = 3'd3,
    REG_HP_ALPHA_ALT  = 3'd4,
    REG_BQ_FEED_GAIN  = 3'd5,
    REG_BQ_FEEDBACK1  = 3'd6,
    REG_BQ_FEEDBACK2  = 3'd7
  } reg_index_t;

  localparam int MODE_MODEL_A_BIT = 0;
  localparam int MODE_BIQUAD_BIT  = 1;

  typedef struct packed {
    logic [1:0]         filter_mode;
    logic [15:0]        master_volume;
    logic [30:0]        lowpass_alpha;
    logic [30:0]        highpass_alpha_primary;
    logic [30:0]        highpass_alpha_alternate;
    logic signed [31:0] biquad_feed_gain;
    logic signed [31:0] biquad_feedback_one;
    logic signed [31:0] biquad_feedback_two;
  } cfg_t;

  localparam logic [1:0]         RST_FILTER_MODE   = 2'd1;
  localparam logic [15:0]        RST_MASTER_VOLUME = 16'd16384;
  localparam logic [30:0]        RST_LOWPASS_ALPHA = 31'd490270000;
  localparam logic [30:0]        RST_HP_ALPHA_PRI  = 31'd783800;
  localparam logic [30:0]        RST_HP_ALPHA_ALT  = 31'd812800;
  localparam logic signed [31:0] RST_BQ_FEED_GAIN  = 32'sd38690000;
  localparam logic signed [31:0] RST_BQ_FEEDBACK1  = -32'sd1468560000;
  localparam logic signed [31:0] RST_BQ_FEEDBACK2  = 32'sd549650000;

  typedef struct packed {
    logic start;
    logic take;
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

  localparam logic signed [65:0] SAT32_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT32_LO = -66'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT32_HI) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT32_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/srlof_lane.sv
// ----------------------------------------------------------------------------
// srlof_lane
// One channel of the output filter: one-pole stages, optional biquad lowpass
// and volume, stepped through a single shared multiplier.
// ----------------------------------------------------------------------------
module srlof_lane
  import srlof_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cfg_t                           cfg,
  input  lane_ctrl_t                     ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output lane_stat_t                     stat,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

  localparam int IN_SHIFT  = 32 - SAMPLE_WIDTH;
  localparam int OUT_SHIFT = 14 + IN_SHIFT;
  localparam logic signed [65:0] VOL_RND = 66'sd1 <<< (OUT_SHIFT - 1);
  localparam logic signed [65:0] OUT_HI  = (66'sd1 <<< (SAMPLE_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] OUT_LO  = -(66'sd1 <<< (SAMPLE_WIDTH - 1));
  localparam logic signed [65:0] POLE_RND = 66'sd1 <<< 29;
  localparam logic signed [65:0] BQ_RND   = 66'sd1 <<< 21;

  typedef enum logic [17:0] {
    ST_IDLE    = 18'b000000000000000001,
    ST_LP_MUL  = 18'b000000000000000010,
    ST_LP_UPD  = 18'b000000000000000100,
    ST_HP_MUL  = 18'b000000000000001000,
    ST_HP_UPD  = 18'b000000000000010000,
    ST_HA_MUL  = 18'b000000000000100000,
    ST_HA_UPD  = 18'b000000000001000000,
    ST_BQ_M0   = 18'b000000000010000000,
    ST_BQ_M1   = 18'b000000000100000000,
    ST_BQ_M2   = 18'b000000001000000000,
    ST_BQ_M3   = 18'b000000010000000000,
    ST_BQ_M4   = 18'b000000100000000000,
    ST_BQ_END  = 18'b000001000000000000,
    ST_BQ_RND  = 18'b000010000000000000,
    ST_VOL_MUL = 18'b000100000000000000,
    ST_VOL_UPD = 18'b001000000000000000,
    ST_DONE    = 18'b010000000000000000,
    ST_SPARE   = 18'b100000000000000000
  } state_t;

  state_t state, state_next;

  logic signed [31:0] s;
  logic signed [31:0] lp_hold, hp_hold, ha_hold;
  logic signed [31:0] h0, h1, h2, h3;
  logic signed [65:0] prod;
  logic signed [59:0] acc;
  logic signed [SAMPLE_WIDTH-1:0] res;

  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] hold_mul, hold_upd, hold_new, pole_out, bq_y;
  logic [30:0]        alpha_sel;
  logic signed [65:0] step_w, vol_w;
  logic signed [59:0] term8, term7;

  always_comb begin
    case (state)
      ST_LP_MUL: begin hold_mul = lp_hold; alpha_sel = cfg.lowpass_alpha; end
      ST_HP_MUL: begin hold_mul = hp_hold; alpha_sel = cfg.highpass_alpha_primary; end
      default:   begin hold_mul = ha_hold; alpha_sel = cfg.highpass_alpha_alternate; end
    endcase
  end

  always_comb begin
    case (state)
      ST_LP_MUL, ST_HP_MUL, ST_HA_MUL: begin
        mul_a = 33'(s) - 33'(hold_mul);
        mul_b = $signed({2'b00, alpha_sel});
      end
      ST_BQ_M0: begin mul_a = 33'(s);  mul_b = 33'(cfg.biquad_feed_gain);    end
      ST_BQ_M1: begin mul_a = 33'(h0); mul_b = 33'(cfg.biquad_feed_gain);    end
      ST_BQ_M2: begin mul_a = 33'(h1); mul_b = 33'(cfg.biquad_feed_gain);    end
      ST_BQ_M3: begin mul_a = 33'(h2); mul_b = 33'(cfg.biquad_feedback_one); end
      ST_BQ_M4: begin mul_a = 33'(h3); mul_b = 33'(cfg.biquad_feedback_two); end
      default: begin
        mul_a = 33'(s);
        mul_b = $signed({17'd0, cfg.master_volume});
      end
    endcase
  end

  always_comb begin
    case (state)
      ST_LP_UPD: hold_upd = lp_hold;
      ST_HP_UPD: hold_upd = hp_hold;
      default:   hold_upd = ha_hold;
    endcase
    step_w   = (prod + POLE_RND) >>> 30;
    hold_new = sat32(66'(hold_upd) + step_w);
    pole_out = sat32(66'(s) - 66'(hold_new));
    term8    = 60'(prod >>> 8);
    term7    = 60'(prod >>> 7);
    bq_y     = sat32((66'(acc) + BQ_RND) >>> 22);
    vol_w    = (prod + VOL_RND) >>> OUT_SHIFT;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (ctrl.start) begin
          state_next = cfg.filter_mode[MODE_MODEL_A_BIT] ? ST_LP_MUL : ST_HA_MUL;
        end
      end
      ST_LP_MUL: state_next = ST_LP_UPD;
      ST_LP_UPD: state_next = ST_HP_MUL;
      ST_HP_MUL: state_next = ST_HP_UPD;
      ST_HA_MUL: state_next = ST_HA_UPD;
      ST_HP_UPD, ST_HA_UPD: begin
        state_next = cfg.filter_mode[MODE_BIQUAD_BIT] ? ST_BQ_M0 : ST_VOL_MUL;
      end
      ST_BQ_M0:   state_next = ST_BQ_M1;
      ST_BQ_M1:   state_next = ST_BQ_M2;
      ST_BQ_M2:   state_next = ST_BQ_M3;
      ST_BQ_M3:   state_next = ST_BQ_M4;
      ST_BQ_M4:   state_next = ST_BQ_END;
      ST_BQ_END:  state_next = ST_BQ_RND;
      ST_BQ_RND:  state_next = ST_VOL_MUL;
      ST_VOL_MUL: state_next = ST_VOL_UPD;
      ST_VOL_UPD: state_next = ST_DONE;
      ST_DONE: begin
        if (ctrl.take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      lp_hold <= '0;
      hp_hold <= '0;
      ha_hold <= '0;
      h0      <= '0;
      h1      <= '0;
      h2      <= '0;
      h3      <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_LP_UPD: lp_hold <= hold_new;
        ST_HP_UPD: hp_hold <= hold_new;
        ST_HA_UPD: ha_hold <= hold_new;
        ST_BQ_RND: begin
          h1 <= h0;
          h0 <= s;
          h3 <= h2;
          h2 <= bq_y;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        if (ctrl.start) begin
          s <= 32'(sample_in) <<< IN_SHIFT;
        end
      end
      ST_LP_UPD: s <= hold_new;
      ST_HP_UPD, ST_HA_UPD: s <= pole_out;
      ST_BQ_M1:  acc <= term8;
      ST_BQ_M2:  acc <= acc + term7;
      ST_BQ_M3:  acc <= acc + term8;
      ST_BQ_M4:  acc <= acc - term8;
      ST_BQ_END: acc <= acc - term8;
      ST_BQ_RND: s <= bq_y;
      ST_VOL_UPD: begin
        if (vol_w > OUT_HI) begin
          res <= OUT_HI[SAMPLE_WIDTH-1:0];
        end else if (vol_w < OUT_LO) begin
          res <= OUT_LO[SAMPLE_WIDTH-1:0];
        end else begin
          res <= vol_w[SAMPLE_WIDTH-1:0];
        end
      end
      default: ;
    endcase
  end

  assign stat.busy  = (state != ST_IDLE);
  assign stat.done  = (state == ST_DONE);
  assign sample_out = res;

endmodule

FILE: rtl/srlof_merge.sv
// ----------------------------------------------------------------------------
// srlof_merge
// Joins the left and right lane results into one stereo output transaction
// held in an output register.
// ----------------------------------------------------------------------------
module srlof_merge
  import srlof_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lane_stat_t                     stat_l,
  input  lane_stat_t                     stat_r,
  input  logic signed [SAMPLE_WIDTH-1:0] res_l,
  input  logic signed [SAMPLE_WIDTH-1:0] res_r,
  output logic                           take,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] left_out,
  output logic signed [SAMPLE_WIDTH-1:0] right_out
);

  assign take = stat_l.done && stat_r.done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      left_out  <= res_l;
      right_out <= res_r;
    end
  end

endmodule

FILE: rtl/stereo_rc_led_output_filter.sv
// ----------------------------------------------------------------------------
// stereo_rc_led_output_filter
// Stereo output filter: one-pole RC lowpass/highpass or alternate highpass,
// optional biquad lowpass, master volume, with saturated outputs.
// ----------------------------------------------------------------------------
// Left and right run in two identical lanes, each stepping its own
// 33x33 multiplier through its filter chain: the RC lowpass and highpass
// pair or the alternate highpass, then the optional biquad, then the
// volume. Both lanes then wait in their done state until the merge block
// hands the pair to the output register. The lanes return to idle before
// taking the next frame, so a new frame is not taken until the last one
// has been handed on; a stalled output holds the lanes in their hand-off
// state. Configuration writes are taken every cycle and should be made
// while no frame is in flight.
module stereo_rc_led_output_filter
  import srlof_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] left_in,
  input  logic signed [SAMPLE_WIDTH-1:0] right_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] left_out,
  output logic signed [SAMPLE_WIDTH-1:0] right_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_INDEX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data
);

  cfg_t       cfg;
  lane_ctrl_t ctrl;
  lane_stat_t stat_l, stat_r;
  logic signed [SAMPLE_WIDTH-1:0] res_l, res_r;
  logic take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_mode              <= RST_FILTER_MODE;
      cfg.master_volume            <= RST_MASTER_VOLUME;
      cfg.lowpass_alpha            <= RST_LOWPASS_ALPHA;
      cfg.highpass_alpha_primary   <= RST_HP_ALPHA_PRI;
      cfg.highpass_alpha_alternate <= RST_HP_ALPHA_ALT;
      cfg.biquad_feed_gain         <= RST_BQ_FEED_GAIN;
      cfg.biquad_feedback_one      <= RST_BQ_FEEDBACK1;
      cfg.biquad_feedback_two      <= RST_BQ_FEEDBACK2;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_FILTER_MODE:   cfg.filter_mode              <= cfg_data[1:0];
        REG_MASTER_VOLUME: cfg.master_volume            <= cfg_data[15:0];
        REG_LOWPASS_ALPHA: cfg.lowpass_alpha            <= cfg_data[30:0];
        REG_HP_ALPHA_PRI:  cfg.highpass_alpha_primary   <= cfg_data[30:0];
        REG_HP_ALPHA_ALT:  cfg.highpass_alpha_alternate <= cfg_data[30:0];
        REG_BQ_FEED_GAIN:  cfg.biquad_feed_gain         <= $signed(cfg_data);
        REG_BQ_FEEDBACK1:  cfg.biquad_feedback_one      <= $signed(cfg_data);
        REG_BQ_FEEDBACK2:  cfg.biquad_feedback_two      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign in_ready   = !stat_l.busy && !stat_r.busy;
  assign ctrl.start = in_valid && in_ready;
  assign ctrl.take  = take;

  srlof_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_l (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .ctrl       (ctrl),
    .sample_in  (left_in),
    .stat       (stat_l),
    .sample_out (res_l)
  );

  srlof_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_r (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .ctrl       (ctrl),
    .sample_in  (right_in),
    .stat       (stat_r),
    .sample_out (res_r)
  );

  srlof_merge #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .stat_l    (stat_l),
    .stat_r    (stat_r),
    .res_l     (res_l),
    .res_r     (res_r),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out)
  );

endmodule

FILE: rtl/srlof_checker.sv
// ----------------------------------------------------------------------------
// srlof_checker
// Port-level checks on the stereo output filter, bound to the top level.
// ----------------------------------------------------------------------------
module srlof_checker
  import srlof_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] left_out,
  input logic [SAMPLE_WIDTH-1:0] right_out,
  input logic                    cfg_valid,
  input logic                    cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
    else $error("output transaction dropped or changed while stalled");

  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second frame accepted while one is in flight");

  a_no_instant_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("output appeared without filter latency");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind stereo_rc_led_output_filter srlof_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_srlof_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .left_out  (left_out),
  .right_out (right_out),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

FILE: bench/tb_stereo_rc_led_output_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_rc_led_output_filter
// Self-checking bench for the stereo RC output filter. A scripted run walks
// sample extremes, all four filter modes, alpha overshoot, saturating
// biquad coefficients, register masking and zero volume. Random register
// settings follow, each with a stream of random stereo frames. Every frame is
// predicted in the bench and compared field by field. Sender bursts, receiver
// stalls and one long receiver hold-off exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_stereo_rc_led_output_filter;
  import srlof_pkg::*;

  localparam int SW          = 24;
  localparam int NUM_ROWS    = 34;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 60;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;

  typedef logic signed [SW-1:0] sample_t;
  typedef logic signed [31:0]   word_t;
  typedef logic signed [79:0]   wide_t;

  typedef struct packed {
    sample_t l;
    sample_t r;
  } stereo_t;

  typedef struct packed {
    bit          is_reg;
    reg_index_t  idx;
    logic [31:0] data;
    sample_t     l;
    sample_t     r;
    bit          typed;
    sample_t     el;
    sample_t     er;
  } script_row_t;

  localparam sample_t S_MAX  = 24'sh7FFFFF;
  localparam sample_t S_MIN  = 24'sh800000;
  localparam sample_t S_ZERO = 24'sh000000;

  localparam wide_t W32_HI    = 80'sd2147483647;
  localparam wide_t W32_LO    = -80'sd2147483648;
  localparam wide_t OUT_HI    = 80'sd8388607;
  localparam wide_t OUT_LO    = -80'sd8388608;
  localparam wide_t ROUND_Q30 = 80'sd536870912;
  localparam wide_t ROUND_Q22 = 80'sd2097152;

  localparam logic [31:0] ALPHA_EDGES [3] = '{32'h0000_0000, 32'h4000_0000, 32'h7FFF_FFFF};
  localparam logic [31:0] COEF_EDGES  [3] = '{32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF};

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  sample_t    left_in   = '0;
  sample_t    right_in  = '0;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  reg_index_t cfg_index = REG_FILTER_MODE;
  logic [31:0] cfg_data = '0;
  logic       in_ready;
  logic       out_valid;
  logic       cfg_ready;
  sample_t    left_out;
  sample_t    right_out;

  stereo_rc_led_output_filter #(
    .SAMPLE_WIDTH(SW)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .left_in  (left_in),
    .right_in (right_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .left_out (left_out),
    .right_out(right_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // filter state mirror: index 0 left, 1 right
  cfg_t    cfg_model;
  word_t   lp_y   [2];
  word_t   hpa_y  [2];
  word_t   hpb_y  [2];
  word_t   bq_mem [2][4];  // x1, x2, y1, y2

  stereo_t     pending_frames [$];
  stereo_t     got_frame;
  script_row_t script_rows [NUM_ROWS];

  int err_cnt      = 0;
  int cycle_cnt    = 0;
  int frames_sent  = 0;
  int results_seen = 0;
  int reg_writes   = 0;
  int burst_left   = 0;
  bit gaps_on      = 1'b1;
  int hold_asks    = 0;
  int holds_served = 0;
  int hold_left    = 0;
  int pattern_left = 0;
  int stall_style  = 0;

  function automatic word_t clamp32(wide_t v);
    if (v > W32_HI) begin
      return 32'sh7FFFFFFF;
    end else if (v < W32_LO) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic word_t one_pole_step(word_t y, wide_t x, logic [30:0] alpha);
    wide_t d, a, stepv, sum;
    d     = x - y;
    a     = alpha;
    stepv = (d * a + ROUND_Q30) >>> 30;
    sum   = y;
    sum   = sum + stepv;
    return clamp32(sum);
  endfunction

  function automatic word_t biquad_step(int ch, word_t s);
    wide_t a1, b1, b2, acc;
    word_t y;
    a1  = $signed(cfg_model.biquad_feed_gain);
    b1  = $signed(cfg_model.biquad_feedback_one);
    b2  = $signed(cfg_model.biquad_feedback_two);
    acc = ((a1 * s) >>> 8) + ((a1 * bq_mem[ch][0]) >>> 7) + ((a1 * bq_mem[ch][1]) >>> 8)
        - ((b1 * bq_mem[ch][2]) >>> 8) - ((b2 * bq_mem[ch][3]) >>> 8);
    y = clamp32((acc + ROUND_Q22) >>> 22);
    bq_mem[ch][1] = bq_mem[ch][0];
    bq_mem[ch][0] = s;
    bq_mem[ch][3] = bq_mem[ch][2];
    bq_mem[ch][2] = y;
    return y;
  endfunction

  function automatic stereo_t predict_filtered_frame(sample_t l, sample_t r);
    stereo_t res;
    wide_t   x, s, vol, v;
    sample_t o;
    vol = cfg_model.master_volume;
    for (int ch = 0; ch < 2; ch++) begin
      x = (ch == 0) ? l : r;
      x = x <<< (32 - SW);
      if (cfg_model.filter_mode[MODE_MODEL_A_BIT]) begin
        lp_y[ch]  = one_pole_step(lp_y[ch], x, cfg_model.lowpass_alpha);
        hpa_y[ch] = one_pole_step(hpa_y[ch], lp_y[ch], cfg_model.highpass_alpha_primary);
        s = lp_y[ch];
        s = clamp32(s - hpa_y[ch]);
      end else begin
        hpb_y[ch] = one_pole_step(hpb_y[ch], x, cfg_model.highpass_alpha_alternate);
        s = clamp32(x - hpb_y[ch]);
      end
      if (cfg_model.filter_mode[MODE_BIQUAD_BIT]) begin
        s = biquad_step(ch, s[31:0]);
      end
      v = (s * vol + ROUND_Q22) >>> (14 + 32 - SW);
      if (v > OUT_HI) begin
        o = S_MAX;
      end else if (v < OUT_LO) begin
        o = S_MIN;
      end else begin
        o = v[SW-1:0];
      end
      if (ch == 0) begin
        res.l = o;
      end else begin
        res.r = o;
      end
    end
    return res;
  endfunction

  function automatic void apply_reg(reg_index_t idx, logic [31:0] data);
    case (idx)
      REG_FILTER_MODE:   cfg_model.filter_mode              = data[1:0];
      REG_MASTER_VOLUME: cfg_model.master_volume            = data[15:0];
      REG_LOWPASS_ALPHA: cfg_model.lowpass_alpha            = data[30:0];
      REG_HP_ALPHA_PRI:  cfg_model.highpass_alpha_primary   = data[30:0];
      REG_HP_ALPHA_ALT:  cfg_model.highpass_alpha_alternate = data[30:0];
      REG_BQ_FEED_GAIN:  cfg_model.biquad_feed_gain         = data;
      REG_BQ_FEEDBACK1:  cfg_model.biquad_feedback_one      = data;
      REG_BQ_FEEDBACK2:  cfg_model.biquad_feedback_two      = data;
      default: ;
    endcase
  endfunction

  function automatic sample_t next_sample(sample_t prev);
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(0, 5))
      0, 1:    return raw[SW-1:0];
      2:       return raw[19:0] - 24'd524288;
      3:       return raw[0] ? S_MAX : S_MIN;
      4:       return prev;
      default: return -prev;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (err_cnt < 30) begin
      $display("mismatch: %s on result %0d: got %0d want %0d", what, results_seen, got, want);
    end
    err_cnt++;
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    reg_writes++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  task automatic send_frame(sample_t l, sample_t r, bit typed, sample_t el, sample_t er);
    stereo_t want;
    in_valid <= 1'b1;
    left_in  <= l;
    right_in <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = predict_filtered_frame(l, r);
    if (typed) begin
      want.l = el;
      want.r = er;
    end
    pending_frames.push_back(want);
    frames_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  // receiver: stall patterns, plus a long hold-off on request
  always @(posedge clk) begin
    if (holds_served != hold_asks) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        stall_style  = $urandom_range(0, 3);
        pattern_left = $urandom_range(20, 120);
      end
      pattern_left--;
      case (stall_style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= $urandom_range(0, 1);
        2:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= (cycle_cnt % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("result with nothing pending", left_out, 0);
      end else begin
        got_frame = pending_frames.pop_front();
        if (left_out !== got_frame.l) report_mismatch("left_out", left_out, got_frame.l);
        if (right_out !== got_frame.r) report_mismatch("right_out", right_out, got_frame.r);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frames pending", cycle_cnt, pending_frames.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    sample_t     pl, pr;
    logic [31:0] mode_w, vol_w, lp_w, hpa_w, hpb_w, g_w, f1_w, f2_w;

    cfg_model.filter_mode              = RST_FILTER_MODE;
    cfg_model.master_volume            = RST_MASTER_VOLUME;
    cfg_model.lowpass_alpha            = RST_LOWPASS_ALPHA;
    cfg_model.highpass_alpha_primary   = RST_HP_ALPHA_PRI;
    cfg_model.highpass_alpha_alternate = RST_HP_ALPHA_ALT;
    cfg_model.biquad_feed_gain         = RST_BQ_FEED_GAIN;
    cfg_model.biquad_feedback_one      = RST_BQ_FEEDBACK1;
    cfg_model.biquad_feedback_two      = RST_BQ_FEEDBACK2;
    for (int ch = 0; ch < 2; ch++) begin
      lp_y[ch]  = '0;
      hpa_y[ch] = '0;
      hpb_y[ch] = '0;
      for (int k = 0; k < 4; k++) bq_mem[ch][k] = '0;
    end

    script_rows = '{
      '{1'b0, REG_FILTER_MODE,   32'h0,         S_ZERO,       S_ZERO,       1'b1, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         S_MAX,        S_MAX,        1'b0, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         S_MIN,        S_MIN,        1'b0, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         S_MAX,        S_MIN,        1'b0, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         S_MIN,        S_MAX,        1'b0, S_ZERO, S_ZERO},
      '{1'b1, REG_FILTER_MODE,   32'h0,         S_ZERO,       S_ZERO,       1'b0, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         S_MAX,        S_MIN,        1'b0, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         24'sh555555,  24'shAAAAAA,  1'b0, S_ZERO, S_ZERO},
      '{1'b1, REG_FILTER_MODE,   32'h3,         S_ZERO,       S_ZERO,       1'b0, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         S_MAX,        S_MAX,        1'b0, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         S_MIN,        S_MIN,        1'b0, S_ZERO, S_ZERO},
      '{1'b1, REG_FILTER_MODE,   32'h2,         S_ZERO,       S_ZERO,       1'b0, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         24'sh123456,  24'shEDCBA9,  1'b0, S_ZERO, S_ZERO},
      '{1'b1, REG_LOWPASS_ALPHA, 32'hFFFF_FFFF, S_ZERO,       S_ZERO,       1'b0, S_ZERO, S_ZERO},
      '{1'b1, REG_FILTER_MODE,   32'hFFFF_FFFD, S_ZERO,       S_ZERO,       1'b0, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         S_MAX,        S_MIN,        1'b0, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         S_MIN,        S_MAX,        1'b0, S_ZERO, S_ZERO},
      '{1'b1, REG_BQ_FEED_GAIN,  32'h7FFF_FFFF, S_ZERO,       S_ZERO,       1'b0, S_ZERO, S_ZERO},
      '{1'b1, REG_BQ_FEEDBACK1,  32'h8000_0000, S_ZERO,       S_ZERO,       1'b0, S_ZERO, S_ZERO},
      '{1'b1, REG_BQ_FEEDBACK2,  32'h7FFF_FFFF, S_ZERO,       S_ZERO,       1'b0, S_ZERO, S_ZERO},
      '{1'b1, REG_FILTER_MODE,   32'h3,         S_ZERO,       S_ZERO,       1'b0, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         S_MAX,        S_MAX,        1'b0, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         S_MIN,        S_MIN,        1'b0, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         S_MAX,        S_MIN,        1'b0, S_ZERO, S_ZERO},
      '{1'b1, REG_MASTER_VOLUME, 32'hFFFF_0000, S_ZERO,       S_ZERO,       1'b0, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         S_MAX,        S_MIN,        1'b1, S_ZERO, S_ZERO},
      '{1'b1, REG_MASTER_VOLUME, 32'h0000_FFFF, S_ZERO,       S_ZERO,       1'b0, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         S_MIN,        S_MAX,        1'b0, S_ZERO, S_ZERO},
      '{1'b1, REG_HP_ALPHA_PRI,  32'h0,         S_ZERO,       S_ZERO,       1'b0, S_ZERO, S_ZERO},
      '{1'b1, REG_HP_ALPHA_ALT,  32'h4000_0000, S_ZERO,       S_ZERO,       1'b0, S_ZERO, S_ZERO},
      '{1'b1, REG_FILTER_MODE,   32'h0,         S_ZERO,       S_ZERO,       1'b0, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         S_MAX,        S_MAX,        1'b0, S_ZERO, S_ZERO},
      '{1'b1, REG_FILTER_MODE,   32'h1,         S_ZERO,       S_ZERO,       1'b0, S_ZERO, S_ZERO},
      '{1'b0, REG_FILTER_MODE,   32'h0,         S_MIN,        S_MIN,        1'b0, S_ZERO, S_ZERO}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // scripted part: register rows wait for the pipe to drain
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (script_rows[i].is_reg) begin
        wait_idle();
        write_reg(script_rows[i].idx, script_rows[i].data);
      end else begin
        cfg_valid <= 1'b0;
        send_frame(script_rows[i].l, script_rows[i].r, script_rows[i].typed,
                   script_rows[i].el, script_rows[i].er);
      end
    end

    pl = '0;
    pr = '0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p % 3)
        0: begin
          vol_w = $urandom_range(0, 32768);
          lp_w  = $urandom_range(32'h0400_0000, 32'h4000_0000);
          hpa_w = $urandom_range(0, 32'h0040_0000);
          hpb_w = $urandom_range(0, 32'h0040_0000);
          g_w   = RST_BQ_FEED_GAIN;
          f1_w  = RST_BQ_FEEDBACK1;
          f2_w  = RST_BQ_FEEDBACK2;
        end
        1: begin
          vol_w = $urandom();
          lp_w  = $urandom();
          hpa_w = $urandom();
          hpb_w = $urandom();
          g_w   = $urandom();
          f1_w  = $urandom();
          f2_w  = $urandom();
        end
        default: begin
          vol_w = $urandom_range(0, 1) ? 32'h0000_FFFF : 32'h0;
          lp_w  = ALPHA_EDGES[$urandom_range(0, 2)];
          hpa_w = ALPHA_EDGES[$urandom_range(0, 2)];
          hpb_w = ALPHA_EDGES[$urandom_range(0, 2)];
          g_w   = COEF_EDGES[$urandom_range(0, 2)];
          f1_w  = COEF_EDGES[$urandom_range(0, 2)];
          f2_w  = COEF_EDGES[$urandom_range(0, 2)];
        end
      endcase
      mode_w = ($urandom() & ~32'd3) | (p % 4);
      write_reg(REG_MASTER_VOLUME, vol_w);
      write_reg(REG_LOWPASS_ALPHA, lp_w);
      write_reg(REG_HP_ALPHA_PRI, hpa_w);
      write_reg(REG_HP_ALPHA_ALT, hpb_w);
      write_reg(REG_BQ_FEED_GAIN, g_w);
      write_reg(REG_BQ_FEEDBACK1, f1_w);
      write_reg(REG_BQ_FEEDBACK2, f2_w);
      write_reg(REG_FILTER_MODE, mode_w);
      cfg_valid <= 1'b0;

      gaps_on = (p % 4 != 1) && (p != 2);
      if (p == 2) hold_asks++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n == PHASE_ITEMS / 2) wait_idle();
        pl = next_sample(pl);
        pr = next_sample(pr);
        send_frame(pl, pr, 1'b0, S_ZERO, S_ZERO);
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("summary: %0d frames sent, %0d results checked, %0d register writes",
             frames_sent, results_seen, reg_writes);
    $display("summary: all filter modes, coefficient extremes, hold-off and backpressure");
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
